### rtl/lzssd_pkg.sv
// shared types and constants for the lzss decoder with a 4k ring window
package lzssd_pkg;

   localparam int WINDOW_DEPTH_DEF = 4096;
   localparam int RING_AW          = 12;
   localparam int LEN_W            = 24;
   localparam int CNT_W            = 5;
   localparam int CMD_FIFO_DEPTH   = 2;
   localparam int CSR_IDX_W        = 1;

   localparam logic [RING_AW-1:0] RING_START = 12'hfee;
   localparam logic [7:0]         INV_MASK   = 8'hff;
   localparam logic [CNT_W-1:0]   LEN_BIAS   = 5'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_MODE   = 1'b1;

   typedef enum logic [1:0] {
      PHASE_FLAG  = 2'd0,
      PHASE_TOKEN = 2'd1,
      PHASE_HIGH  = 2'd2
   } phase_type;

   // one unit of work for the copy engine
   typedef struct packed {
      logic                 clear;
      logic                 is_match;
      logic [7:0]           lit;
      logic [RING_AW-1:0]   pos;
      logic [CNT_W-1:0]     count;
      logic                 done;
   } cmd_type;

endpackage

### rtl/lzss_decoder_4k_window_top.sv
// top level of the lzss decoder with a 4k ring window
//
//   channel   prefix  direction  carries
//   ------------------------------------------------------------------
//   request   req_    in         code_byte, stream_start
//   response  rsp_    out        data_byte, run_last, stream_done
//   config    csr_    in         index, data (output_length, invert_mode)
//
// a flag byte or the first byte of a match is taken by the parser without issuing a command
// a literal gives one byte in the copy engine, a match of n bytes gives n bytes
// (one ring read per byte), so a match gives at most 18 bytes
// the parser runs up to two commands ahead through the command queue
// reset: synchronous, active high; the ring needs no clearing pass, a fill count
// makes entries not yet written in the current stream read as zero
// a stalled response holds the output register, the engine and queue back up behind it
module lzss_decoder_4k_window_top
   import lzssd_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   // compressed byte input
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_code_byte,
   input  logic                  req_stream_start,
   // decoded byte output
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_data_byte,
   output logic                  rsp_run_last,
   output logic                  rsp_stream_done,
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [LEN_W-1:0]      csr_data
);

   // configuration registers; the user writes them only while the decoder is idle, the block does not enforce it
   logic [LEN_W-1:0] out_len_ff, out_len_in;
   logic             invert_ff, invert_in;

   // parser to queue to engine
   logic     push, fifo_full, pop, fifo_empty;
   cmd_type  push_cmd, pop_cmd;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      out_len_in = out_len_ff;
      invert_in  = invert_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_OUTPUT_LENGTH: out_len_in = csr_data;
            CSR_INVERT_MODE:   invert_in  = csr_data[0];
            default: begin
               out_len_in = out_len_ff;
               invert_in  = invert_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_len_ff <= '0;
         invert_ff  <= 1'b0;
      end else begin
         out_len_ff <= out_len_in;
         invert_ff  <= invert_in;
      end
   end

   // token parser: flags, match byte pairing, output length bookkeeping
   lzssd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_code_byte    (req_code_byte),
      .req_stream_start (req_stream_start),
      .output_length    (out_len_ff),
      .invert_mode      (invert_ff),
      .fifo_full        (fifo_full),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   // decouples the parser from the copy engine
   lzssd_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (fifo_full),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .empty    (fifo_empty)
   );

   // copy engine with the ring window and the response register
   lzssd_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .fifo_empty      (fifo_empty),
      .pop_cmd         (pop_cmd),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_stream_done (rsp_stream_done)
   );

endmodule

### rtl/lzssd_front.sv
// token parser: takes compressed bytes, tracks flag state and output count, issues commands
module lzssd_front
   import lzssd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_code_byte,
   input  logic              req_stream_start,
   input  logic [LEN_W-1:0]  output_length,
   input  logic              invert_mode,
   input  logic              fifo_full,
   output logic              push,
   output cmd_type           push_cmd
);

   phase_type          phase_ff, phase_in;
   logic [7:0]         shift_ff, shift_in;
   logic [3:0]         bits_ff, bits_in;
   logic [7:0]         low_ff, low_in;
   logic [LEN_W-1:0]   prod_ff, prod_in;
   logic               pend_clear_ff, pend_clear_in;

   logic               accept;
   logic [7:0]         code;
   phase_type          eff_phase;
   logic [7:0]         eff_shift;
   logic [3:0]         eff_bits;
   logic [LEN_W-1:0]   eff_prod;
   logic               finished;
   logic               tok_lit, tok_low, tok_high;
   logic [CNT_W-1:0]   mlen;
   logic [LEN_W-1:0]   rem;
   logic [CNT_W-1:0]   mcount;
   logic               clear_now;

   assign req_ready = !fifo_full;
   assign accept    = req_valid && req_ready;
   assign code      = req_code_byte ^ (invert_mode ? INV_MASK : 8'h00);

   // classification against the state as seen after an optional stream restart
   always_comb begin
      eff_phase = req_stream_start ? PHASE_FLAG : phase_ff;
      eff_shift = req_stream_start ? 8'h00 : shift_ff;
      eff_bits  = req_stream_start ? 4'd0 : bits_ff;
      eff_prod  = req_stream_start ? '0 : prod_ff;
      finished  = eff_prod >= output_length;
      tok_lit   = !finished && (eff_phase == PHASE_TOKEN) && (eff_bits != 4'd0) && eff_shift[7];
      tok_low   = !finished && (eff_phase == PHASE_TOKEN) && (eff_bits != 4'd0) && !eff_shift[7];
      tok_high  = !finished && (eff_phase == PHASE_HIGH) && (eff_bits != 4'd0);
      mlen      = {1'b0, low_ff[3:0]} + LEN_BIAS;
      rem       = output_length - eff_prod;
      mcount    = (rem < LEN_W'(mlen)) ? rem[CNT_W-1:0] : mlen;
      clear_now = pend_clear_ff || req_stream_start;
   end

   // next state
   always_comb begin
      phase_in      = phase_ff;
      shift_in      = shift_ff;
      bits_in       = bits_ff;
      low_in        = low_ff;
      prod_in       = prod_ff;
      pend_clear_in = pend_clear_ff;
      if (accept) begin
         phase_in      = eff_phase;
         shift_in      = eff_shift;
         bits_in       = eff_bits;
         prod_in       = eff_prod;
         pend_clear_in = clear_now;
         if (req_stream_start) begin
            low_in = 8'h00;
         end
         if (!finished) begin
            if (tok_lit || tok_high) begin
               shift_in      = {eff_shift[6:0], 1'b0};
               bits_in       = eff_bits - 4'd1;
               phase_in      = (eff_bits == 4'd1) ? PHASE_FLAG : PHASE_TOKEN;
               pend_clear_in = 1'b0;
               prod_in       = tok_lit ? eff_prod + LEN_W'(1) : eff_prod + LEN_W'(mcount);
            end else if (tok_low) begin
               low_in   = code;
               phase_in = PHASE_HIGH;
            end else begin
               shift_in = code;
               bits_in  = 4'd8;
               phase_in = PHASE_TOKEN;
            end
         end
      end
   end

   // command output
   always_comb begin
      push              = accept && (tok_lit || tok_high);
      push_cmd.clear    = clear_now;
      push_cmd.is_match = tok_high;
      push_cmd.lit      = code;
      push_cmd.pos      = {code, low_ff[7:4]};
      push_cmd.count    = tok_high ? mcount : CNT_W'(1);
      push_cmd.done     = tok_high ? (rem <= LEN_W'(mlen)) : (rem == LEN_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_FLAG;
         shift_ff      <= 8'h00;
         bits_ff       <= 4'd0;
         low_ff        <= 8'h00;
         prod_ff       <= '0;
         pend_clear_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         shift_ff      <= shift_in;
         bits_ff       <= bits_in;
         low_ff        <= low_in;
         prod_ff       <= prod_in;
         pend_clear_ff <= pend_clear_in;
      end
   end

endmodule

### rtl/lzssd_cmd_fifo.sv
// short command queue between parser and copy engine
module lzssd_cmd_fifo
   import lzssd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  cmd_type  push_cmd,
   output logic     full,
   input  logic     pop,
   output cmd_type  pop_cmd,
   output logic     empty
);

   localparam int PW = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
   localparam logic [PW:0]   DEPTH_CNT = (PW+1)'(CMD_FIFO_DEPTH);
   localparam logic [PW-1:0] LAST_IDX  = PW'(CMD_FIFO_DEPTH - 1);

   cmd_type       slot_ff [CMD_FIFO_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign full    = cnt_ff == DEPTH_CNT;
   assign empty   = cnt_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

### rtl/lzssd_back.sv
// copy engine: ring window memory, byte-per-cycle match copy while the output is not stalled, and output register
module lzssd_back
   import lzssd_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        fifo_empty,
   input  cmd_type     pop_cmd,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_run_last,
   output logic        rsp_stream_done
);

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam logic [AW:0]   FILL_MAX = (AW+1)'(WINDOW_DEPTH);
   localparam logic [AW-1:0] WP_START = AW'(RING_START);

   logic [7:0]       ring_mem [WINDOW_DEPTH];
   logic [7:0]       ring_q_ff;

   // read stage
   logic             act_ff, act_in;
   logic             a_match_ff, a_match_in;
   logic [7:0]       a_lit_ff, a_lit_in;
   logic [AW-1:0]    a_pos_ff, a_pos_in;
   logic [CNT_W-1:0] a_left_ff, a_left_in;
   logic             a_done_ff, a_done_in;

   // byte stage
   logic             b_vld_ff, b_vld_in;
   logic             b_use_mem_ff, b_use_mem_in;
   logic [7:0]       b_data_ff, b_data_in;
   logic             b_last_ff, b_last_in;
   logic             b_done_ff, b_done_in;

   // write side of the ring
   logic [AW-1:0]    wp_ff, wp_in;
   logic [AW:0]      fill_ff, fill_in;

   // output register
   logic             rsp_vld_ff, rsp_vld_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_done_ff, rsp_done_in;

   logic             out_free, b_fire, issue, issue_last;
   logic [7:0]       b_byte;
   logic [AW-1:0]    rd_off;
   logic             filled, fwd;

   always_comb begin
      out_free   = !rsp_vld_ff || rsp_ready;
      b_fire     = b_vld_ff && out_free;
      b_byte     = b_use_mem_ff ? ring_q_ff : b_data_ff;
      issue      = act_ff && (!b_vld_ff || b_fire);
      issue_last = issue && (a_left_ff == CNT_W'(1));
      // a restart waits until every byte of the old stream has left the ring path
      pop        = !fifo_empty &&
                   (pop_cmd.clear ? (!act_ff && !b_vld_ff) : (!act_ff || issue_last));
      // entries written since the restart run from the start pointer upward
      rd_off     = a_pos_ff - WP_START;
      filled     = {1'b0, rd_off} < fill_ff;
      fwd        = b_fire && (a_pos_ff == wp_ff);
   end

   always_comb begin
      act_in     = act_ff;
      a_match_in = a_match_ff;
      a_lit_in   = a_lit_ff;
      a_pos_in   = a_pos_ff;
      a_left_in  = a_left_ff;
      a_done_in  = a_done_ff;
      if (pop) begin
         act_in     = 1'b1;
         a_match_in = pop_cmd.is_match;
         a_lit_in   = pop_cmd.lit;
         a_pos_in   = AW'(pop_cmd.pos);
         a_left_in  = pop_cmd.count;
         a_done_in  = pop_cmd.done;
      end else if (issue) begin
         act_in    = !issue_last;
         a_pos_in  = a_pos_ff + AW'(1);
         a_left_in = a_left_ff - CNT_W'(1);
      end
   end

   always_comb begin
      b_vld_in     = b_vld_ff;
      b_use_mem_in = b_use_mem_ff;
      b_data_in    = b_data_ff;
      b_last_in    = b_last_ff;
      b_done_in    = b_done_ff;
      if (issue) begin
         b_vld_in     = 1'b1;
         b_last_in    = a_left_ff == CNT_W'(1);
         b_done_in    = a_done_ff && (a_left_ff == CNT_W'(1));
         b_use_mem_in = a_match_ff && !fwd && filled;
         // unwritten entries read as zero, a same-cycle write is forwarded
         b_data_in    = !a_match_ff ? a_lit_ff : (fwd ? b_byte : 8'h00);
      end else if (b_fire) begin
         b_vld_in = 1'b0;
      end
   end

   always_comb begin
      wp_in   = wp_ff;
      fill_in = fill_ff;
      if (pop && pop_cmd.clear) begin
         wp_in   = WP_START;
         fill_in = '0;
      end else if (b_fire) begin
         wp_in   = wp_ff + AW'(1);
         fill_in = (fill_ff == FILL_MAX) ? fill_ff : fill_ff + (AW+1)'(1);
      end
   end

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      rsp_done_in = rsp_done_ff;
      if (out_free) begin
         rsp_vld_in = b_vld_ff;
         if (b_vld_ff) begin
            rsp_data_in = b_byte;
            rsp_last_in = b_last_ff;
            rsp_done_in = b_done_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_fire) begin
         ring_mem[wp_ff] <= b_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (issue && a_match_ff) begin
         ring_q_ff <= ring_mem[a_pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      a_match_ff   <= a_match_in;
      a_lit_ff     <= a_lit_in;
      a_pos_ff     <= a_pos_in;
      a_left_ff    <= a_left_in;
      a_done_ff    <= a_done_in;
      b_use_mem_ff <= b_use_mem_in;
      b_data_ff    <= b_data_in;
      b_last_ff    <= b_last_in;
      b_done_ff    <= b_done_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_done_ff  <= rsp_done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff     <= 1'b0;
         b_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
         wp_ff      <= WP_START;
         fill_ff    <= '0;
      end else begin
         act_ff     <= act_in;
         b_vld_ff   <= b_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         wp_ff      <= wp_in;
         fill_ff    <= fill_in;
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_data_byte   = rsp_data_ff;
   assign rsp_run_last    = rsp_last_ff;
   assign rsp_stream_done = rsp_done_ff;

endmodule

### rtl/lzssd_chk.sv
// port-level checks for the lzss decoder, bound to the top level
module lzssd_chk (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_run_last,
   input logic       rsp_stream_done
);

   // a stalled response transaction keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_byte) &&
         $stable(rsp_run_last) && $stable(rsp_stream_done))
      else $error("response changed while stalled");

   // reset empties the output register
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // reset empties the command queue so input is taken at once
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not ready right after reset");

   // the stream always ends on the last byte of an input transaction
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_done |-> rsp_run_last)
      else $error("stream_done without run_last");

endmodule

bind lzss_decoder_4k_window_top lzssd_chk u_chk (.*);

### dv/lzss_decode_checker.sv
// checker for the lzss decoder: decodes accepted bytes alongside the block and compares results
module lzss_decode_checker
   import lzssd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [7:0]            req_code_byte,
   input  logic                  req_stream_start,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [7:0]            rsp_data_byte,
   input  logic                  rsp_run_last,
   input  logic                  rsp_stream_done,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [LEN_W-1:0]      csr_data,
   output int                    err_count,
   output int                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       done;
   } decoded_byte_t;

   decoded_byte_t expected_bytes[$];

   // decoder state
   logic [7:0]         ring [WINDOW_DEPTH_DEF];
   logic [RING_AW-1:0] wr_ptr;
   logic [7:0]         flag_sh;
   logic [3:0]         flags_left;
   phase_type          phase;
   logic [7:0]         match_lo;
   logic [LEN_W-1:0]   produced;
   logic [LEN_W-1:0]   out_len;
   logic               invert;

   task automatic clear_stream_state();
      foreach (ring[i]) ring[i] = 8'h00;
      wr_ptr     = RING_START;
      flag_sh    = 8'h00;
      flags_left = 4'd0;
      phase      = PHASE_FLAG;
      match_lo   = 8'h00;
      produced   = '0;
   endtask

   task automatic emit_byte(input logic [7:0] v);
      decoded_byte_t e;
      ring[wr_ptr] = v;
      wr_ptr       = wr_ptr + 1'b1;
      produced     = produced + 1'b1;
      e.data = v;
      e.last = 1'b0;
      e.done = (produced == out_len);
      expected_bytes.push_back(e);
   endtask

   task automatic end_token();
      flag_sh = flag_sh << 1;
      if (flags_left != 4'd0) flags_left = flags_left - 1'b1;
      phase = (flags_left == 4'd0) ? PHASE_FLAG : PHASE_TOKEN;
   endtask

   task automatic decode_code_byte(input logic [7:0] raw, input logic start);
      logic [7:0]         b;
      logic [RING_AW-1:0] pos;
      int                 len;
      int                 base;
      int                 j;
      base = expected_bytes.size();
      if (start) clear_stream_state();
      // finished stream swallows everything until the next start
      if (produced >= out_len) return;
      b = invert ? (raw ^ INV_MASK) : raw;
      if (phase == PHASE_TOKEN && flags_left != 4'd0) begin
         if (flag_sh[7]) begin
            emit_byte(b);
            end_token();
         end else begin
            match_lo = b;
            phase    = PHASE_HIGH;
         end
      end else if (phase == PHASE_HIGH && flags_left != 4'd0) begin
         pos = {b, match_lo[7:4]};
         len = int'(match_lo[3:0]) + 3;
         // byte by byte so overlapping copies repeat
         for (j = 0; j < len && produced < out_len; j++) begin
            emit_byte(ring[pos]);
            pos = pos + 1'b1;
         end
         end_token();
      end else begin
         flag_sh    = b;
         flags_left = 4'd8;
         phase      = PHASE_TOKEN;
      end
      if (expected_bytes.size() > base)
         expected_bytes[expected_bytes.size()-1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      decoded_byte_t e;
      if (reset) begin
         clear_stream_state();
         out_len   = '0;
         invert    = 1'b0;
         err_count = 0;
         expected_bytes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t unexpected result data_byte %02h run_last %0b stream_done %0b",
                        $time, rsp_data_byte, rsp_run_last, rsp_stream_done);
               err_count++;
            end else begin
               e = expected_bytes.pop_front();
               if (rsp_data_byte !== e.data) begin
                  $display("%0t data_byte mismatch expected %02h actual %02h",
                           $time, e.data, rsp_data_byte);
                  err_count++;
               end
               if (rsp_run_last !== e.last) begin
                  $display("%0t run_last mismatch expected %0b actual %0b",
                           $time, e.last, rsp_run_last);
                  err_count++;
               end
               if (rsp_stream_done !== e.done) begin
                  $display("%0t stream_done mismatch expected %0b actual %0b",
                           $time, e.done, rsp_stream_done);
                  err_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_OUTPUT_LENGTH) out_len = csr_data;
            else if (csr_index == CSR_INVERT_MODE) invert = csr_data[0];
         end
         if (req_valid && req_ready) decode_code_byte(req_code_byte, req_stream_start);
      end
      pending_count = expected_bytes.size();
   end

endmodule

### dv/tb_lzss_decoder_4k_window_top.sv
// testbench top for the lzss decoder: stimulus, flow control and verdict
module tb_lzss_decoder_4k_window_top;
   timeunit 1ns;
   timeprecision 1ps;
   import lzssd_pkg::*;

   localparam int RESET_CYCLES    = 9;
   localparam int ITEM_TARGET     = 260;
   // covers a full command queue plus the longest match draining
   localparam int IDLE_SETTLE     = 25;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT     = 1_000_000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_code_byte = 8'h00;
   logic                 req_stream_start = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [7:0]           rsp_data_byte;
   logic                 rsp_run_last;
   logic                 rsp_stream_done;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_OUTPUT_LENGTH;
   logic [LEN_W-1:0]     csr_data = '0;
   int                   err_count;
   int                   pending_count;

   // flow control knobs shared by the drivers
   bit sender_burst = 1'b0;
   bit rsp_burst    = 1'b0;
   bit hold_go      = 1'b0;

   // what the stimulus side knows of the stream it is building, used to aim matches
   logic [LEN_W-1:0]   gen_len = '0;
   bit                 gen_inv = 1'b0;
   int                 gen_produced = 0;
   logic [RING_AW-1:0] gen_wp = RING_START;
   int                 items_live = 0;
   int                 cycle_count = 0;

   lzss_decoder_4k_window_top DUT (.*);

   lzss_decode_checker decode_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 14) return $urandom_range(1, 3);
      if (r < 19) return $urandom_range(4, 8);
      return $urandom_range(15, 40);
   endfunction

   // response side: random stalls, bursts of steady ready, one long hold-off on request
   initial begin
      bit hold_done;
      int stall_left;
      hold_done  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_go && !hold_done) begin
            // block backs up and must drop req_ready while the sender keeps offering
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES - 1) @(negedge clock);
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!rsp_burst && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
         if ($urandom_range(0, 199) == 0) rsp_burst = !rsp_burst;
      end
   end

   // one request transaction; valid stays up across back-to-back items
   task automatic send_raw(input logic [7:0] b, input logic start);
      int gap;
      gap = (sender_burst || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_code_byte    <= b;
      req_stream_start <= start;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [LEN_W-1:0] len, input bit inv);
      write_csr(CSR_OUTPUT_LENGTH, len);
      write_csr(CSR_INVERT_MODE, LEN_W'(inv));
      gen_len = len;
      gen_inv = inv;
   endtask

   // stop offering, drain every expected byte, then let the block settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   // plain decoded value in, the wire byte follows the invert setting
   task automatic put_byte(input logic [7:0] v, input logic start);
      items_live++;
      send_raw(gen_inv ? (v ^ INV_MASK) : v, start);
   endtask

   task automatic begin_stream(input logic [7:0] flag);
      gen_produced = 0;
      gen_wp       = RING_START;
      put_byte(flag, 1'b1);
   endtask

   task automatic put_literal(input logic [7:0] v);
      put_byte(v, 1'b0);
      if (gen_produced < gen_len) begin
         gen_produced++;
         gen_wp = gen_wp + 1'b1;
      end
   endtask

   task automatic put_match(input logic [RING_AW-1:0] pos, input int len);
      int n;
      put_byte({pos[3:0], 4'(len - 3)}, 1'b0);
      put_byte(pos[11:4], 1'b0);
      if (gen_produced < gen_len) begin
         // a match past the end gets cut short
         n = (len < int'(gen_len) - gen_produced) ? len : int'(gen_len) - gen_produced;
         gen_produced += n;
         gen_wp = gen_wp + RING_AW'(n);
      end
   endtask

   // mostly a short distance back into what this stream wrote, so copies overlap
   function automatic logic [RING_AW-1:0] pick_pos();
      int span;
      if (gen_produced == 0 || $urandom_range(0, 4) == 0) return RING_AW'($urandom);
      span = (gen_produced < 40) ? gen_produced : 40;
      return gen_wp - RING_AW'($urandom_range(1, span));
   endfunction

   function automatic logic [7:0] pick_flag();
      int r;
      r = $urandom_range(0, 5);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hff;
      return 8'($urandom);
   endfunction

   function automatic logic [LEN_W-1:0] pick_length();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return LEN_W'($urandom_range(1, 8));
      if (r == 1) return {LEN_W{1'b1}};
      if (r == 2) return LEN_W'($urandom);
      if (r == 3) return '0;
      return LEN_W'($urandom_range(20, 150));
   endfunction

   // flag byte and the eight tokens it announces; now and then cut off mid-token
   task automatic send_group(input logic [7:0] flag, input logic start, output bit abandoned);
      int k;
      abandoned = 1'b0;
      if (start) begin_stream(flag);
      else put_byte(flag, 1'b0);
      for (k = 7; k >= 0; k--) begin
         if (!start && $urandom_range(0, 59) == 0) begin
            put_byte(8'($urandom), 1'b0);
            abandoned = 1'b1;
            return;
         end
         if (flag[k]) put_literal(8'($urandom));
         else put_match(pick_pos(), $urandom_range(3, 18));
      end
   endtask

   initial begin
      int                 stream_no;
      int                 n_groups;
      int                 g;
      bit                 abandoned;
      logic [LEN_W-1:0]   lowered;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero length: the whole stream is ignored
      set_config('0, 1'b0);
      begin_stream(8'hff);
      put_literal(8'h41);

      // full length, plain bytes: extreme fields, longest and shortest match,
      // a distance-one copy that repeats one byte
      wait_idle();
      set_config({LEN_W{1'b1}}, 1'b0);
      begin_stream(8'ha0);
      put_literal(8'h00);
      put_match(12'hfff, 18);
      put_literal(8'hff);
      put_match(gen_wp - 1'b1, 16);
      put_match(RING_START, 5);
      put_match(12'h000, 3);
      put_match(12'h010, 18);
      put_match(12'h003, 3);

      // inverted bytes, length 4: the match gets cut and the trailing byte is dropped
      wait_idle();
      set_config(LEN_W'(4), 1'b1);
      begin_stream(8'hc0);
      put_literal(8'h55);
      put_literal(8'hff);
      put_match(RING_START, 18);
      put_byte(8'h12, 1'b0);

      // random streams
      stream_no = 0;
      while (items_live < ITEM_TARGET) begin
         // sender waits here until every expected byte is back
         wait_idle();
         if (stream_no == 1) set_config(LEN_W'(2000), 1'($urandom));
         else set_config(pick_length(), 1'($urandom));
         sender_burst = ($urandom_range(0, 3) == 0);
         n_groups  = (stream_no == 1) ? 6 : $urandom_range(2, 6);
         abandoned = 1'b0;
         for (g = 0; g < n_groups && !abandoned; g++) begin
            // second stream is all matches under a long response hold-off
            send_group((stream_no == 1) ? 8'h00 : pick_flag(), g == 0, abandoned);
            if (stream_no == 1 && g == 0) hold_go = 1'b1;
         end
         // cut the length down mid-stream, sometimes to exactly what is already out
         if (!abandoned && $urandom_range(0, 4) == 0) begin
            wait_idle();
            lowered = LEN_W'(gen_produced + $urandom_range(0, 6));
            write_csr(CSR_OUTPUT_LENGTH, lowered);
            gen_len = lowered;
            send_group(pick_flag(), 1'b0, abandoned);
         end
         // stray bytes after the stream
         if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom), 1'b0);
         stream_no++;
      end

      wait_idle();
      if (err_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
